// ===== sv/m2es_pkg.sv =====
// Shared types and constants for the MPEG-2 elementary stream header scanner.
// Holds the channel payload structs, start code values and the frame rate tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package m2es_pkg;

	// start code ids and prefix
	localparam logic [23:0] START_PREFIX = 24'h000001;
	localparam logic [23:0] RECENT_IDLE  = 24'hFFFFFF;
	localparam logic [7:0]  ID_SEQ_HDR   = 8'hB3;
	localparam logic [7:0]  ID_SEQ_EXT   = 8'hB5;
	localparam logic [7:0]  ID_PICTURE   = 8'h00;
	localparam logic [3:0]  EXT_ID_SEQ   = 4'h1;

	// header being gathered
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_SEQ  = 2'd1;
	localparam logic [1:0] KIND_EXT  = 2'd2;
	localparam logic [1:0] KIND_PIC  = 2'd3;

	// bytes after the id that complete each header
	localparam logic [2:0] LEN_SEQ = 3'd7;
	localparam logic [2:0] LEN_EXT = 3'd4;
	localparam logic [2:0] LEN_PIC = 3'd2;

	localparam logic [38:0] RATE_UNIT = 39'd400;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic        seq_header_seen;
		logic        seq_ext_seen;
		logic        picture_seen;
		logic [11:0] frame_width;
		logic [11:0] frame_height;
		logic [38:0] bit_rate;
		logic [15:0] rate_numerator;
		logic [9:0]  rate_denominator;
		logic [2:0]  picture_type;
	} hdr_item_t;

	// raw values captured when a result is due
	typedef struct packed {
		logic [2:0]  seen;
		logic [11:0] width;
		logic [11:0] height;
		logic [17:0] rate_base;
		logic [11:0] rate_ext;
		logic [3:0]  rate_code;
		logic [2:0]  coding_type;
	} raw_result_t;

	function automatic logic [15:0] rate_num(input logic [3:0] code);
		logic [15:0] v;
		unique case (code)
			4'd1:    v = 16'd24000;
			4'd2:    v = 16'd24;
			4'd3:    v = 16'd25;
			4'd4:    v = 16'd30000;
			4'd5:    v = 16'd30;
			4'd6:    v = 16'd50;
			4'd7:    v = 16'd60000;
			4'd8:    v = 16'd60;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	function automatic logic [9:0] rate_den(input logic [3:0] code);
		logic [9:0] v;
		unique case (code)
			4'd1, 4'd4, 4'd7:             v = 10'd1001;
			4'd2, 4'd3, 4'd5, 4'd6, 4'd8: v = 10'd1;
			default:                      v = 10'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== sv/mpeg2_es_header_scanner.sv =====
// MPEG-2 video elementary stream header scanner, top level.
// Depends on m2es_pkg for payload structs, start codes and frame rate tables.
//
// Usage:
//   byte channel (byte_valid/byte_ready/byte_data): one stream byte per transfer,
//   with last_byte marking the final byte of a buffer.
//   hdr channel (hdr_valid/hdr_ready/hdr_data): one summary per buffer, given as
//   soon as a sequence header, a sequence extension and a picture header were all
//   found, or at the buffer's last byte otherwise. Bytes after an early summary
//   are skipped up to the last byte; the last byte always clears the scan state.
// Throughput: one byte per clock unless stalled; the scan state updates in the
//   cycle of the transfer, so every byte enters straight behind the one before.
// Path: a summary enters stage 1 at the transfer of the byte that causes it and
//   moves on to the output register once that is empty or being read; frame rate
//   lookup and the bit rate multiply by 400 sit in that second stage.
// Stall: a summary waits in stage 1 while hdr_valid is high and hdr_ready low;
//   byte_ready drops only when stage 1 holds a summary that cannot move on.
//   While it is low no byte is taken, whether or not it would complete a summary.
// Reset: arst_n clears the scan state and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module mpeg2_es_header_scanner (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   byte_valid,
	output logic                  byte_ready,
	input  m2es_pkg::byte_item_t  byte_data,
	output logic                  hdr_valid,
	input  wire                   hdr_ready,
	output m2es_pkg::hdr_item_t   hdr_data
);

	// scan state
	logic [23:0] recent_q;
	logic [1:0]  kind_q;
	logic [2:0]  count_q;
	logic [55:0] field_q;
	logic [11:0] width_q;
	logic [11:0] height_q;
	logic [17:0] base_q;
	logic [11:0] ext_q;
	logic [3:0]  code_q;
	logic [2:0]  ctype_q;
	logic [2:0]  seen_q;
	logic        reported_q;

	logic [23:0] recent_d;
	logic [1:0]  kind_d;
	logic [2:0]  count_d;
	logic [55:0] field_d;
	logic [11:0] width_d;
	logic [11:0] height_d;
	logic [17:0] base_d;
	logic [11:0] ext_d;
	logic [3:0]  code_d;
	logic [2:0]  ctype_d;
	logic [2:0]  seen_d;
	logic        emit;

	logic [55:0] field_sh;
	logic [2:0]  count_inc;

	logic                  res_valid_s1;
	m2es_pkg::raw_result_t res_s1;
	logic                  s1_move;
	logic                  byte_xfer;
	logic [29:0]           rate_full;
	logic [38:0]           rate_scaled;

	assign s1_move   = res_valid_s1 && (!hdr_valid || hdr_ready);
	assign byte_ready = !res_valid_s1 || s1_move;
	assign byte_xfer = byte_valid && byte_ready;

	assign field_sh  = {field_q[47:0], byte_data.data_byte};
	assign count_inc = count_q + 3'd1;

	// parse one byte
	always_comb begin
		recent_d = {recent_q[15:0], byte_data.data_byte};
		kind_d   = kind_q;
		count_d  = count_q;
		field_d  = field_q;
		width_d  = width_q;
		height_d = height_q;
		base_d   = base_q;
		ext_d    = ext_q;
		code_d   = code_q;
		ctype_d  = ctype_q;
		seen_d   = seen_q;
		if (recent_q == m2es_pkg::START_PREFIX) begin
			count_d = 3'd0;
			field_d = '0;
			priority if (byte_data.data_byte == m2es_pkg::ID_SEQ_HDR) begin
				kind_d = m2es_pkg::KIND_SEQ;
			end else if (byte_data.data_byte == m2es_pkg::ID_SEQ_EXT) begin
				kind_d = m2es_pkg::KIND_EXT;
			end else if (byte_data.data_byte == m2es_pkg::ID_PICTURE) begin
				kind_d = m2es_pkg::KIND_PIC;
			end else begin
				kind_d = m2es_pkg::KIND_NONE;
			end
		end else if (kind_q != m2es_pkg::KIND_NONE) begin
			field_d = field_sh;
			count_d = count_inc;
			if (kind_q == m2es_pkg::KIND_SEQ && count_inc == m2es_pkg::LEN_SEQ) begin
				width_d   = field_sh[55:44];
				height_d  = field_sh[43:32];
				code_d    = field_sh[27:24];
				base_d    = field_sh[23:6];
				seen_d[0] = 1'b1;
				kind_d    = m2es_pkg::KIND_NONE;
			end else if (kind_q == m2es_pkg::KIND_EXT && count_inc == m2es_pkg::LEN_EXT) begin
				if (field_sh[31:28] == m2es_pkg::EXT_ID_SEQ) begin
					ext_d     = field_sh[12:1];
					seen_d[1] = 1'b1;
				end
				kind_d = m2es_pkg::KIND_NONE;
			end else if (kind_q == m2es_pkg::KIND_PIC && count_inc == m2es_pkg::LEN_PIC) begin
				ctype_d   = field_sh[5:3];
				seen_d[2] = 1'b1;
				kind_d    = m2es_pkg::KIND_NONE;
			end
		end
		emit = !reported_q && ((seen_d == 3'b111) || byte_data.last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q   <= m2es_pkg::RECENT_IDLE;
			kind_q     <= m2es_pkg::KIND_NONE;
			count_q    <= '0;
			field_q    <= '0;
			width_q    <= '0;
			height_q   <= '0;
			base_q     <= '0;
			ext_q      <= '0;
			code_q     <= '0;
			ctype_q    <= '0;
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (byte_xfer) begin
			if (byte_data.last_byte) begin
				// end of buffer: start over
				recent_q   <= m2es_pkg::RECENT_IDLE;
				kind_q     <= m2es_pkg::KIND_NONE;
				count_q    <= '0;
				field_q    <= '0;
				width_q    <= '0;
				height_q   <= '0;
				base_q     <= '0;
				ext_q      <= '0;
				code_q     <= '0;
				ctype_q    <= '0;
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				recent_q   <= recent_d;
				kind_q     <= kind_d;
				count_q    <= count_d;
				field_q    <= field_d;
				width_q    <= width_d;
				height_q   <= height_d;
				base_q     <= base_d;
				ext_q      <= ext_d;
				code_q     <= code_d;
				ctype_q    <= ctype_d;
				seen_q     <= seen_d;
				reported_q <= emit;
			end
		end
	end

	// stage 1: raw summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (byte_xfer) begin
			res_valid_s1 <= emit;
		end else if (s1_move) begin
			res_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_xfer && emit) begin
			res_s1.seen        <= seen_d;
			res_s1.width       <= width_d;
			res_s1.height      <= height_d;
			res_s1.rate_base   <= base_d;
			res_s1.rate_ext    <= ext_d;
			res_s1.rate_code   <= code_d;
			res_s1.coding_type <= ctype_d;
		end
	end

	// stage 2: scale bit rate, look up frame rate
	assign rate_full   = {res_s1.rate_ext, res_s1.rate_base};
	assign rate_scaled = {9'd0, rate_full} * m2es_pkg::RATE_UNIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid <= 1'b0;
		end else if (s1_move) begin
			hdr_valid <= 1'b1;
		end else if (hdr_ready) begin
			hdr_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			hdr_data.seq_header_seen  <= res_s1.seen[0];
			hdr_data.seq_ext_seen     <= res_s1.seen[1];
			hdr_data.picture_seen     <= res_s1.seen[2];
			hdr_data.frame_width      <= res_s1.width;
			hdr_data.frame_height     <= res_s1.height;
			hdr_data.bit_rate         <= (res_s1.seen[0] && res_s1.seen[1]) ?
				rate_scaled : {21'd0, res_s1.rate_base};
			hdr_data.rate_numerator   <= m2es_pkg::rate_num(res_s1.rate_code);
			hdr_data.rate_denominator <= m2es_pkg::rate_den(res_s1.rate_code);
			hdr_data.picture_type     <= res_s1.coding_type;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking bench for mpeg2_es_header_scanner: random byte buffers built from real
// header shapes, a scan predictor that tracks every byte, and a summary checker.
// Depends on m2es_pkg for the payload structs and start code constants.
`timescale 1ns / 1ps

module testbench;

	localparam int TOTAL_BYTES = 1750;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AFTER  = 5;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 8;
	localparam int SAW_SEQ     = 0;
	localparam int SAW_EXT     = 1;
	localparam int SAW_PIC     = 2;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_ready;
	m2es_pkg::byte_item_t byte_data = '0;
	logic                 hdr_valid;
	logic                 hdr_ready = 1'b0;
	m2es_pkg::hdr_item_t  hdr_data;

	m2es_pkg::byte_item_t pending_bytes[$];
	m2es_pkg::hdr_item_t  due_summaries[$];

	int byte_gap = 0;
	int hold_left = 0;
	bit calm_send = 1'b1;
	bit calm_recv = 1'b0;
	int bytes_sent = 0;
	int buffers = 0;
	int summaries_checked = 0;
	int mismatches = 0;
	int input_stalls = 0;
	int cycles = 0;

	// scan state of the predictor
	logic [23:0] tail3;
	logic [1:0]  gather_kind;
	logic [3:0]  gathered;
	logic [63:0] hdr_bits;
	logic [11:0] cur_width;
	logic [11:0] cur_height;
	logic [17:0] cur_rate_base;
	logic [11:0] cur_rate_ext;
	logic [3:0]  cur_rate_code;
	logic [2:0]  cur_coding;
	logic [2:0]  found;
	logic        summary_sent;

	mpeg2_es_header_scanner uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.hdr_valid  (hdr_valid),
		.hdr_ready  (hdr_ready),
		.hdr_data   (hdr_data)
	);

	always #5 clk = ~clk;

	task automatic clear_scan();
		tail3 = m2es_pkg::RECENT_IDLE;
		gather_kind = m2es_pkg::KIND_NONE;
		gathered = '0;
		hdr_bits = '0;
		cur_width = '0;
		cur_height = '0;
		cur_rate_base = '0;
		cur_rate_ext = '0;
		cur_rate_code = '0;
		cur_coding = '0;
		found = '0;
		summary_sent = 1'b0;
	endtask

	// {numerator, denominator}; codes outside the table give zeros
	function automatic logic [25:0] frame_rate(input logic [3:0] code);
		case (code)
			4'd1:    return {16'd24000, 10'd1001};
			4'd2:    return {16'd24, 10'd1};
			4'd3:    return {16'd25, 10'd1};
			4'd4:    return {16'd30000, 10'd1001};
			4'd5:    return {16'd30, 10'd1};
			4'd6:    return {16'd50, 10'd1};
			4'd7:    return {16'd60000, 10'd1001};
			4'd8:    return {16'd60, 10'd1};
			default: return '0;
		endcase
	endfunction

	function automatic m2es_pkg::hdr_item_t summarize();
		m2es_pkg::hdr_item_t s;
		logic [63:0] rate;
		logic [25:0] fr;
		if (found[SAW_SEQ] && found[SAW_EXT])
			rate = ((64'(cur_rate_ext) << 18) + 64'(cur_rate_base)) *
				64'(m2es_pkg::RATE_UNIT);
		else
			rate = 64'(cur_rate_base);
		fr = frame_rate(cur_rate_code);
		s.seq_header_seen = found[SAW_SEQ];
		s.seq_ext_seen = found[SAW_EXT];
		s.picture_seen = found[SAW_PIC];
		s.frame_width = cur_width;
		s.frame_height = cur_height;
		s.bit_rate = rate[38:0];
		s.rate_numerator = fr[25:10];
		s.rate_denominator = fr[9:0];
		s.picture_type = cur_coding;
		return s;
	endfunction

	task automatic scan_byte(input logic [7:0] b);
		if (tail3 == m2es_pkg::START_PREFIX) begin
			// a fresh start code drops whatever header was being gathered
			gathered = '0;
			hdr_bits = '0;
			case (b)
				m2es_pkg::ID_SEQ_HDR: gather_kind = m2es_pkg::KIND_SEQ;
				m2es_pkg::ID_SEQ_EXT: gather_kind = m2es_pkg::KIND_EXT;
				m2es_pkg::ID_PICTURE: gather_kind = m2es_pkg::KIND_PIC;
				default:              gather_kind = m2es_pkg::KIND_NONE;
			endcase
		end else if (gather_kind != m2es_pkg::KIND_NONE) begin
			hdr_bits = {hdr_bits[55:0], b};
			gathered = gathered + 4'd1;
			if (gather_kind == m2es_pkg::KIND_SEQ &&
				gathered == 4'(m2es_pkg::LEN_SEQ)) begin
				cur_width = hdr_bits[55:44];
				cur_height = hdr_bits[43:32];
				cur_rate_code = hdr_bits[27:24];
				cur_rate_base = hdr_bits[23:6];
				found[SAW_SEQ] = 1'b1;
				gather_kind = m2es_pkg::KIND_NONE;
			end else if (gather_kind == m2es_pkg::KIND_EXT &&
				gathered == 4'(m2es_pkg::LEN_EXT)) begin
				if (hdr_bits[31:28] == m2es_pkg::EXT_ID_SEQ) begin
					cur_rate_ext = hdr_bits[12:1];
					found[SAW_EXT] = 1'b1;
				end
				gather_kind = m2es_pkg::KIND_NONE;
			end else if (gather_kind == m2es_pkg::KIND_PIC &&
				gathered == 4'(m2es_pkg::LEN_PIC)) begin
				cur_coding = hdr_bits[5:3];
				found[SAW_PIC] = 1'b1;
				gather_kind = m2es_pkg::KIND_NONE;
			end
		end
		tail3 = {tail3[15:0], b};
	endtask

	task automatic predict_transfer(input m2es_pkg::byte_item_t it);
		if (summary_sent) begin
			// skip up to the last byte once the summary went out
			if (it.last_byte)
				clear_scan();
		end else begin
			scan_byte(it.data_byte);
			if (found == 3'b111 || it.last_byte) begin
				due_summaries.push_back(summarize());
				summary_sent = 1'b1;
			end
			if (it.last_byte)
				clear_scan();
		end
	endtask

	task automatic compare_summary(input m2es_pkg::hdr_item_t want,
		input m2es_pkg::hdr_item_t got);
		int bad;
		bad = 0;
		if (got.seq_header_seen !== want.seq_header_seen) begin
			$error("seq_header_seen: expected %0d, got %0d", want.seq_header_seen,
				got.seq_header_seen);
			bad = 1;
		end
		if (got.seq_ext_seen !== want.seq_ext_seen) begin
			$error("seq_ext_seen: expected %0d, got %0d", want.seq_ext_seen, got.seq_ext_seen);
			bad = 1;
		end
		if (got.picture_seen !== want.picture_seen) begin
			$error("picture_seen: expected %0d, got %0d", want.picture_seen, got.picture_seen);
			bad = 1;
		end
		if (got.frame_width !== want.frame_width) begin
			$error("frame_width: expected %0d, got %0d", want.frame_width, got.frame_width);
			bad = 1;
		end
		if (got.frame_height !== want.frame_height) begin
			$error("frame_height: expected %0d, got %0d", want.frame_height, got.frame_height);
			bad = 1;
		end
		if (got.bit_rate !== want.bit_rate) begin
			$error("bit_rate: expected %0d, got %0d", want.bit_rate, got.bit_rate);
			bad = 1;
		end
		if (got.rate_numerator !== want.rate_numerator) begin
			$error("rate_numerator: expected %0d, got %0d", want.rate_numerator,
				got.rate_numerator);
			bad = 1;
		end
		if (got.rate_denominator !== want.rate_denominator) begin
			$error("rate_denominator: expected %0d, got %0d", want.rate_denominator,
				got.rate_denominator);
			bad = 1;
		end
		if (got.picture_type !== want.picture_type) begin
			$error("picture_type: expected %0d, got %0d", want.picture_type, got.picture_type);
			bad = 1;
		end
		mismatches += bad;
	endtask

	function automatic int draw_idle(input bit calm);
		if (calm)
			return 0;
		return int'($urandom_range(0, 6));
	endfunction

	// zero, all ones, or random content for a field of the given width
	function automatic logic [31:0] pick_bits(input int bits);
		logic [31:0] mask;
		mask = (32'd1 << bits) - 32'd1;
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return mask;
			default: return $urandom & mask;
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] b, input logic last);
		m2es_pkg::byte_item_t it;
		it.data_byte = b;
		it.last_byte = last;
		pending_bytes.push_back(it);
	endtask

	task automatic add_prefix(input logic [7:0] id);
		add_byte(m2es_pkg::START_PREFIX[23:16], 1'b0);
		add_byte(m2es_pkg::START_PREFIX[15:8], 1'b0);
		add_byte(m2es_pkg::START_PREFIX[7:0], 1'b0);
		add_byte(id, 1'b0);
	endtask

	task automatic add_seq_header(input logic [11:0] w, input logic [11:0] h,
		input logic [3:0] code, input logic [17:0] base, input int keep);
		logic [55:0] body;
		body = 56'({$urandom, $urandom});
		body[55:44] = w;
		body[43:32] = h;
		body[27:24] = code;
		body[23:6] = base;
		add_prefix(m2es_pkg::ID_SEQ_HDR);
		for (int i = 0; i < keep; i++)
			add_byte(body[55 - 8 * i -: 8], 1'b0);
	endtask

	task automatic add_extension(input logic [3:0] id, input logic [11:0] ext, input int keep);
		logic [31:0] body;
		body = $urandom;
		body[31:28] = id;
		body[12:1] = ext;
		add_prefix(m2es_pkg::ID_SEQ_EXT);
		for (int i = 0; i < keep; i++)
			add_byte(body[31 - 8 * i -: 8], 1'b0);
	endtask

	task automatic add_picture(input logic [2:0] coding, input int keep);
		logic [15:0] body;
		body = 16'($urandom);
		body[5:3] = coding;
		add_prefix(m2es_pkg::ID_PICTURE);
		for (int i = 0; i < keep; i++)
			add_byte(body[15 - 8 * i -: 8], 1'b0);
	endtask

	task automatic add_random_buffer();
		int parts;
		logic [3:0] ext_id;
		parts = int'($urandom_range(0, 6));
		for (int k = 0; k < parts; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: add_seq_header(12'(pick_bits(12)), 12'(pick_bits(12)),
					4'($urandom_range(0, 15)), 18'(pick_bits(18)),
					int'(m2es_pkg::LEN_SEQ));
				3, 4: begin
					ext_id = ($urandom_range(0, 4) != 0) ? m2es_pkg::EXT_ID_SEQ :
						4'($urandom_range(0, 15));
					add_extension(ext_id, 12'(pick_bits(12)), int'(m2es_pkg::LEN_EXT));
				end
				5, 6: add_picture(3'($urandom_range(0, 7)), int'(m2es_pkg::LEN_PIC));
				7: begin
					// cut a header short; the next start code takes over
					case ($urandom_range(0, 2))
						0: add_seq_header(12'(pick_bits(12)), 12'(pick_bits(12)),
							4'($urandom_range(0, 15)), 18'(pick_bits(18)),
							int'($urandom_range(0, int'(m2es_pkg::LEN_SEQ) - 1)));
						1: add_extension(m2es_pkg::EXT_ID_SEQ, 12'(pick_bits(12)),
							int'($urandom_range(0, int'(m2es_pkg::LEN_EXT) - 1)));
						default: add_picture(3'($urandom_range(0, 7)),
							int'($urandom_range(0, int'(m2es_pkg::LEN_PIC) - 1)));
					endcase
				end
				8: repeat ($urandom_range(1, 6)) add_byte(8'($urandom), 1'b0);
				default: begin
					// extra leading zeros, then a start code with a random id
					repeat ($urandom_range(0, 3)) add_byte(8'h00, 1'b0);
					add_prefix(8'($urandom));
				end
			endcase
		end
		add_byte(8'($urandom), 1'b1);
		buffers++;
	endtask

	// byte side: hold valid and payload until the transfer, then idle for a drawn gap
	always @(posedge clk) begin
		bit holding;
		if (arst_n) begin
			if (byte_valid && !byte_ready)
				input_stalls++;
			if (byte_valid && byte_ready) begin
				predict_transfer(byte_data);
				bytes_sent++;
				if (bytes_sent % 128 == 0)
					calm_send = ($urandom_range(0, 3) == 0);
				byte_gap = draw_idle(calm_send);
				holding = 1'b0;
			end else begin
				holding = byte_valid;
			end
			if (!holding) begin
				if (byte_gap == 0 && pending_bytes.size() != 0) begin
					byte_data <= pending_bytes.pop_front();
					byte_valid <= 1'b1;
				end else begin
					byte_valid <= 1'b0;
					if (byte_gap != 0)
						byte_gap--;
				end
			end
		end
	end

	// summary side: check each transfer, then stall for a drawn count
	always @(posedge clk) begin
		if (arst_n) begin
			if (hdr_valid && hdr_ready) begin
				if (due_summaries.size() == 0) begin
					$error("summary transfer with no summary expected");
					mismatches++;
				end else begin
					compare_summary(due_summaries.pop_front(), hdr_data);
				end
				summaries_checked++;
				if (summaries_checked % 8 == 0)
					calm_recv = ($urandom_range(0, 2) == 0);
				// one long hold-off lets summaries pile up and back-pressure the input
				hold_left = (summaries_checked == HOLD_AFTER) ? LONG_HOLD : draw_idle(calm_recv);
			end else if (hold_left != 0) begin
				hold_left--;
			end
			hdr_ready <= (hold_left == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		clear_scan();

		// empty buffer: one byte, nothing found, all-zero summary
		add_byte(8'h00, 1'b1);
		buffers++;
		// all three headers with top field values (rate code 7), then a skipped last byte
		add_seq_header(12'hFFF, 12'hFFF, 4'd7, 18'h3FFFF, int'(m2es_pkg::LEN_SEQ));
		add_extension(m2es_pkg::EXT_ID_SEQ, 12'hFFF, int'(m2es_pkg::LEN_EXT));
		add_picture(3'd7, int'(m2es_pkg::LEN_PIC));
		add_byte(8'hFF, 1'b1);
		buffers++;

		while (pending_bytes.size() < TOTAL_BYTES)
			add_random_buffer();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || byte_valid)
			@(posedge clk);
		while (due_summaries.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d buffers, checked %0d summaries", bytes_sent, buffers,
			summaries_checked);
		$display("Input held off by output back-pressure for %0d cycles", input_stalls);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
